/* rtl/core/tbsc_pkg.sv */
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types and constants for the tracked box steering command core.
// ----------------------------------------------------------------------------
package tbsc_pkg;

    localparam int WINDOW     = 20;
    localparam int RING_DEPTH = WINDOW - 1;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FRM_W      = $clog2(WINDOW + 1);

    localparam int COORD_W    = 10;
    localparam int OFF_W      = 11;
    localparam int AREA_W     = 2 * COORD_W;
    localparam int FRAC_W     = 16;
    localparam int RATIO_W    = 24;
    localparam int DIV_SHIFT  = RATIO_W - FRAC_W;
    localparam int SUM_W      = RATIO_W + PTR_W;
    localparam int DIV_STEPS  = RATIO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int GAIN_W     = 16;
    localparam int MOVE_W     = 8;
    localparam int STEP_W     = COORD_W + GAIN_W - 12;
    localparam int CMD_W      = 3;

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    // mean strictly inside (0.9, 1.1), compared on the sum
    localparam int unsigned SAFE_BASE = RING_DEPTH * (1 << FRAC_W);
    localparam int unsigned SAFE_LO   = (9 * SAFE_BASE) / 10;
    localparam int unsigned SAFE_HI   = (11 * SAFE_BASE + 9) / 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AIM_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AIM_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_W    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_H    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BAND = 3'd7;

    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BACK    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_DINIT,
        S_DIV,
        S_ACC,
        S_STEP,
        S_RR,
        S_THRH,
        S_THRL,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic load;
        logic area;
        logic div_init;
        logic div_step;
        logic acc;
        logic step;
        logic rr;
        logic thr_hi;
        logic thr_lo;
        logic eval;
    } t_cmd;

    function automatic logic signed [OFF_W-1:0] f_sat_off(input logic signed [OFF_W:0] v);
        logic signed [OFF_W:0] lim;
        lim = (OFF_W+1)'(1023);
        if (v > lim) begin
            return OFF_W'(1023);
        end else if (v < -lim) begin
            return -OFF_W'(1023);
        end
        return v[OFF_W-1:0];
    endfunction

endpackage

/* rtl/core/tbsc_ctrl.sv */
// ----------------------------------------------------------------------------
// tbsc_ctrl
// Sequencer: steps one box through the datapath and owns the result valid.
// ----------------------------------------------------------------------------
module tbsc_ctrl import tbsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic               w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_AREA;
            S_AREA:  n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_ACC;
            S_ACC:   n_state = S_STEP;
            S_STEP:  n_state = S_RR;
            S_RR:    n_state = S_THRH;
            S_THRH:  n_state = S_THRL;
            S_THRL:  n_state = S_EVAL;
            S_EVAL:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load     = i_in_valid;
            S_AREA:  o_cmd.area     = 1'b1;
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_ACC:   o_cmd.acc      = 1'b1;
            S_STEP:  o_cmd.step     = 1'b1;
            S_RR:    o_cmd.rr       = 1'b1;
            S_THRH:  o_cmd.thr_hi   = 1'b1;
            S_THRL:  o_cmd.thr_lo   = 1'b1;
            S_EVAL:  o_cmd.eval     = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DINIT) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_cmd.eval) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_AREA))
        else $error("accepted beat did not start processing");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_ACC))
        else $error("divider ran past its step count");

    a_eval_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |=> r_out_valid)
        else $error("result not flagged valid after evaluation");

endmodule

/* rtl/core/tbsc_dp.sv */
// ----------------------------------------------------------------------------
// tbsc_dp
// Datapath: config registers, centre offsets, serial area divider, ratio
// ring and running sum, steering decision and result register.
// ----------------------------------------------------------------------------
module tbsc_dp import tbsc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [COORD_W-1:0]          i_box_x,
    input  logic [COORD_W-1:0]          i_box_y,
    input  logic [COORD_W-1:0]          i_box_w,
    input  logic [COORD_W-1:0]          i_box_h,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic                        o_safe,
    output logic [CMD_W-1:0]            o_command,
    output logic [MOVE_W-1:0]           o_distance,
    output logic signed [OFF_W-1:0]     o_offset_x,
    output logic signed [OFF_W-1:0]     o_offset_y
);

    // config
    logic [COORD_W-1:0] r_aim_x, r_aim_y, r_ref_w, r_ref_h;
    logic [GAIN_W-1:0]  r_gain;
    logic [MOVE_W-1:0]  r_min, r_max, r_band;
    logic               w_clr;

    // box and derived
    logic [COORD_W-1:0]         r_bx, r_by, r_bw, r_bh;
    logic [AREA_W-1:0]          r_area;
    logic signed [OFF_W-1:0]    r_ox, r_oy;
    logic [COORD_W+1:0]         w_sx, w_sy;
    logic [OFF_W-1:0]           w_cx, w_cy;
    logic signed [OFF_W:0]      w_dx, w_dy;

    // divider
    logic [AREA_W-1:0]          r_rem;
    logic [RATIO_W-1:0]         r_dvd, r_quo;
    logic                       r_sat;
    logic [AREA_W:0]            w_shift, w_diff;
    logic                       w_ge;
    logic [RATIO_W-1:0]         w_ratio;

    // history
    logic [RATIO_W-1:0]         r_ring [RING_DEPTH];
    logic [RATIO_W-1:0]         r_ring_q;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [AREA_W-1:0]          r_last;
    logic [FRM_W-1:0]           r_frames;
    logic [PTR_W-1:0]           r_ptr;
    logic                       r_chk;
    logic                       w_full, w_have;

    // steering
    logic [AREA_W-1:0]          r_p1, r_p2, r_rr;
    logic [AREA_W:0]            r_lhs;
    logic [COORD_W-1:0]         w_ax, w_ay, w_mx;
    logic [COORD_W+GAIN_W-1:0]  w_sprod;
    logic [STEP_W-1:0]          r_step;
    logic                       r_xdom;
    logic [AREA_W+9:0]          r_thr_hi, r_thr_lo, w_lhs;
    logic                       w_safe, w_planar;

    assign w_clr = i_cfg_we && (i_cfg_idx == CFG_REF_W || i_cfg_idx == CFG_REF_H);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aim_x <= COORD_W'(480);
            r_aim_y <= COORD_W'(360);
            r_gain  <= GAIN_W'(1229);
            r_min   <= MOVE_W'(20);
            r_max   <= MOVE_W'(60);
            r_ref_w <= COORD_W'(1);
            r_ref_h <= COORD_W'(1);
            r_band  <= MOVE_W'(51);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AIM_X:     r_aim_x <= i_cfg_data[COORD_W-1:0];
                CFG_AIM_Y:     r_aim_y <= i_cfg_data[COORD_W-1:0];
                CFG_GAIN:      r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_MIN_MOVE:  r_min   <= i_cfg_data[MOVE_W-1:0];
                CFG_MAX_MOVE:  r_max   <= i_cfg_data[MOVE_W-1:0];
                CFG_REF_W:     r_ref_w <= i_cfg_data[COORD_W-1:0];
                CFG_REF_H:     r_ref_h <= i_cfg_data[COORD_W-1:0];
                CFG_SIZE_BAND: r_band  <= i_cfg_data[MOVE_W-1:0];
                default: ;
            endcase
        end
    end

    // centre, round half to even
    assign w_sx = {1'b0, r_bx, 1'b0} + {2'b0, r_bw};
    assign w_sy = {1'b0, r_by, 1'b0} + {2'b0, r_bh};
    assign w_cx = w_sx[COORD_W+1:1] + OFF_W'(w_sx[0] & w_sx[1]);
    assign w_cy = w_sy[COORD_W+1:1] + OFF_W'(w_sy[0] & w_sy[1]);
    assign w_dx = $signed({1'b0, w_cx}) - $signed({2'b0, r_aim_x});
    assign w_dy = $signed({1'b0, w_cy}) - $signed({2'b0, r_aim_y});

    // restoring divider, one quotient bit per step
    assign w_shift = {r_rem, r_dvd[RATIO_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_last});
    assign w_diff  = w_shift - {1'b0, r_last};
    assign w_ratio = r_sat ? RATIO_MAX : r_quo;

    assign w_have = (r_frames != '0);
    assign w_full = (r_frames == FRM_W'(WINDOW));
    assign n_sum  = r_sum - (w_full ? SUM_W'(r_ring_q) : '0) + SUM_W'(w_ratio);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bx <= i_box_x;
            r_by <= i_box_y;
            r_bw <= i_box_w;
            r_bh <= i_box_h;
        end
        if (i_cmd.area) begin
            r_area <= r_bw * r_bh;
            r_ox   <= f_sat_off(w_dx);
            r_oy   <= f_sat_off(w_dy);
        end
        if (i_cmd.div_init) begin
            r_rem <= AREA_W'(r_area >> DIV_SHIFT);
            r_dvd <= {r_area[DIV_SHIFT-1:0], FRAC_W'(0)};
            r_quo <= '0;
            r_sat <= (r_last == '0) ||
                     ({DIV_SHIFT'(0), r_area} >= {r_last, DIV_SHIFT'(0)});
            r_p1  <= r_bw * r_ref_h;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[AREA_W-1:0] : w_shift[AREA_W-1:0];
            r_dvd <= {r_dvd[RATIO_W-2:0], 1'b0};
            r_quo <= {r_quo[RATIO_W-2:0], w_ge};
        end
        if (i_cmd.acc) begin
            r_p2 <= r_bh * r_ref_w;
        end
        if (i_cmd.step) begin
            r_step <= w_sprod[COORD_W+GAIN_W-1:12];
            r_xdom <= (w_ax > w_ay);
        end
        if (i_cmd.rr) begin
            r_rr  <= r_ref_w * r_ref_h;
            r_lhs <= {1'b0, r_p1} + {1'b0, r_p2};
        end
        if (i_cmd.thr_hi) begin
            r_thr_hi <= {(AREA_W+9)'(r_rr) * (AREA_W+9)'(9'd256 + {1'b0, r_band}), 1'b0};
        end
        if (i_cmd.thr_lo) begin
            r_thr_lo <= {(AREA_W+9)'(r_rr) * (AREA_W+9)'(9'd256 - {1'b0, r_band}), 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && w_have) begin
            r_ring[r_ptr] <= w_ratio;
        end
        r_ring_q <= r_ring[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_sum    <= '0;
            r_last   <= '0;
            r_frames <= '0;
            r_ptr    <= '0;
            r_chk    <= 1'b0;
        end else if (i_cmd.acc) begin
            if (w_have) begin
                r_sum <= n_sum;
                r_ptr <= (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            end
            r_chk <= w_full;
            if (!w_full) begin
                r_frames <= r_frames + 1'b1;
            end
            r_last <= r_area;
        end
    end

    // steering
    assign w_ax    = r_ox[OFF_W-1] ? COORD_W'(-r_ox) : r_ox[COORD_W-1:0];
    assign w_ay    = r_oy[OFF_W-1] ? COORD_W'(-r_oy) : r_oy[COORD_W-1:0];
    assign w_mx    = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_sprod = w_mx * r_gain;

    assign w_safe   = !r_chk || (r_sum > SUM_W'(SAFE_LO) && r_sum < SUM_W'(SAFE_HI));
    assign w_planar = (r_step > STEP_W'(r_min));
    assign w_lhs    = {1'b0, r_lhs, 8'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            o_safe     <= w_safe;
            o_offset_x <= r_ox;
            o_offset_y <= r_oy;
            o_command  <= CMD_NONE;
            o_distance <= '0;
            if (w_safe) begin
                if (w_planar) begin
                    o_distance <= (r_step < STEP_W'(r_max)) ? r_step[MOVE_W-1:0] : r_max;
                    if (r_xdom) begin
                        o_command <= r_ox[OFF_W-1] ? CMD_LEFT : CMD_RIGHT;
                    end else begin
                        o_command <= r_oy[OFF_W-1] ? CMD_UP : CMD_DOWN;
                    end
                end else if (w_lhs > r_thr_hi) begin
                    o_command  <= CMD_BACK;
                    o_distance <= r_min;
                end else if (w_lhs < r_thr_lo) begin
                    o_command  <= CMD_FORWARD;
                    o_distance <= r_min;
                end
            end
        end
    end

endmodule

/* rtl/core/tracked_box_steering_command_core.sv */
// ----------------------------------------------------------------------------
// tracked_box_steering_command_core
// One tracked box per beat in, one steering result per beat out.
// ----------------------------------------------------------------------------
// Each box is accepted in the idle state and then steps through the area,
// divider setup, 24-step bit-serial divider that forms the area ratio,
// accumulate, step, reference-area, upper and lower threshold and decision
// states before the sequencer returns to idle to take the next beat; the
// decision state waits while the last result is still untaken. One box is
// processed at a time; a finished result waits in the output register while
// the next box is taken in. Config writes are taken at any time but are meant
// for idle periods; a write to ref_width or ref_height clears the area-rate
// history.
module tracked_box_steering_command_core import tbsc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [39:0]             i_s_axis_tdata,  // box_x, box_y, box_w, box_h
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [39:0]             o_m_axis_tdata,  // safe, command, distance,
                                                     // offset_x, offset_y, pad
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cmd                       w_cmd;
    logic                       w_safe;
    logic [CMD_W-1:0]           w_command;
    logic [MOVE_W-1:0]          w_distance;
    logic signed [OFF_W-1:0]    w_offset_x, w_offset_y;

    tbsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    tbsc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_box_x    (i_s_axis_tdata[9:0]),
        .i_box_y    (i_s_axis_tdata[19:10]),
        .i_box_w    (i_s_axis_tdata[29:20]),
        .i_box_h    (i_s_axis_tdata[39:30]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_safe     (w_safe),
        .o_command  (w_command),
        .o_distance (w_distance),
        .o_offset_x (w_offset_x),
        .o_offset_y (w_offset_y)
    );

    assign o_m_axis_tdata = {6'b0, w_offset_y, w_offset_x, w_distance, w_command, w_safe};

endmodule

/* dv/steer_checker_pkg.sv */
// ----------------------------------------------------------------------------
// steer_checker_pkg
// Box and result types plus the steering checker for the tb. The checker
// keeps its own register copy and area-rate history, works out the result
// of every accepted box, queues it, and compares returned beats against it.
// ----------------------------------------------------------------------------
package steer_checker_pkg;
    import tbsc_pkg::*;

    // x in the low bits, then y, w, h
    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } box_t;

    typedef struct packed {
        logic              safe;
        logic [CMD_W-1:0]  command;
        logic [MOVE_W-1:0] distance;
        logic [OFF_W-1:0]  offset_x;
        logic [OFF_W-1:0]  offset_y;
    } steer_t;

    class steer_checker;
        logic [COORD_W-1:0] aim_x, aim_y, ref_w, ref_h;
        logic [GAIN_W-1:0]  gain;
        logic [MOVE_W-1:0]  min_move, max_move, size_band;

        logic [RATIO_W-1:0] ratio_hist [RING_DEPTH];
        logic [SUM_W-1:0]   ratio_total;
        logic [AREA_W-1:0]  prev_area;
        int unsigned        frames;
        int unsigned        slot;

        steer_t due_cmds [$];
        int     errors;
        int     n_boxes;
        int     n_unsafe;
        int     cmd_count [7];

        function new();
            aim_x     = 10'd480;
            aim_y     = 10'd360;
            gain      = 16'd1229;
            min_move  = 8'd20;
            max_move  = 8'd60;
            ref_w     = 10'd1;
            ref_h     = 10'd1;
            size_band = 8'd51;
            clear_history();
        endfunction

        function void clear_history();
            foreach (ratio_hist[i]) ratio_hist[i] = '0;
            ratio_total = '0;
            prev_area   = '0;
            frames      = 0;
            slot        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_AIM_X:     aim_x = val[COORD_W-1:0];
                CFG_AIM_Y:     aim_y = val[COORD_W-1:0];
                CFG_GAIN:      gain = val[GAIN_W-1:0];
                CFG_MIN_MOVE:  min_move = val[MOVE_W-1:0];
                CFG_MAX_MOVE:  max_move = val[MOVE_W-1:0];
                CFG_REF_W: begin
                    ref_w = val[COORD_W-1:0];
                    clear_history();
                end
                CFG_REF_H: begin
                    ref_h = val[COORD_W-1:0];
                    clear_history();
                end
                CFG_SIZE_BAND: size_band = val[MOVE_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_off(int v);
            if (v > 1023) return 1023;
            if (v < -1023) return -1023;
            return v;
        endfunction

        // predict the result of one accepted box and queue it
        function void take_box(box_t b);
            longint unsigned    area, quot, s10, base, lhs, twice, stride;
            logic [RATIO_W-1:0] ratio;
            int                 sx, sy, cx, cy, ox, oy, ax, ay;
            steer_t             r;

            area       = 64'(b.w) * 64'(b.h);
            r.safe     = 1'b1;
            r.command  = CMD_NONE;
            r.distance = '0;

            if (frames > 0) begin
                if (prev_area == 0) begin
                    ratio = RATIO_MAX;
                end else begin
                    quot  = (area << FRAC_W) / 64'(prev_area);
                    ratio = (quot > 64'(RATIO_MAX)) ? RATIO_MAX : quot[RATIO_W-1:0];
                end
                ratio_total      = ratio_total - ratio_hist[slot] + ratio;
                ratio_hist[slot] = ratio;
                slot             = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
            end
            if (frames >= WINDOW) begin
                s10  = 64'(ratio_total) * 10;
                base = 64'(RING_DEPTH) * 64'd65536;
                if (!(s10 > 9 * base && s10 < 11 * base)) r.safe = 1'b0;
            end else begin
                frames++;
            end
            prev_area = area[AREA_W-1:0];

            // centre rounded half to even
            sx = 2 * int'(b.x) + int'(b.w);
            cx = sx / 2;
            if ((sx % 2 == 1) && (cx % 2 == 1)) cx++;
            sy = 2 * int'(b.y) + int'(b.h);
            cy = sy / 2;
            if ((sy % 2 == 1) && (cy % 2 == 1)) cy++;
            ox = clamp_off(cx - int'(aim_x));
            oy = clamp_off(cy - int'(aim_y));
            r.offset_x = ox[OFF_W-1:0];
            r.offset_y = oy[OFF_W-1:0];

            if (r.safe) begin
                ax     = (ox < 0) ? -ox : ox;
                ay     = (oy < 0) ? -oy : oy;
                stride = (64'(ax > ay ? ax : ay) * 64'(gain)) >> 12;
                if (stride > 64'(min_move)) begin
                    r.distance = (stride < 64'(max_move)) ? stride[MOVE_W-1:0] : max_move;
                    if (ax > ay) r.command = (ox > 0) ? CMD_RIGHT : CMD_LEFT;
                    else         r.command = (oy < 0) ? CMD_UP : CMD_DOWN;
                end else begin
                    lhs   = 256 * (64'(b.w) * 64'(ref_h) + 64'(b.h) * 64'(ref_w));
                    twice = 2 * 64'(ref_w) * 64'(ref_h);
                    if (lhs > twice * (64'd256 + 64'(size_band))) begin
                        r.command  = CMD_BACK;
                        r.distance = min_move;
                    end else if (lhs < twice * (64'd256 - 64'(size_band))) begin
                        r.command  = CMD_FORWARD;
                        r.distance = min_move;
                    end
                end
            end

            due_cmds.push_back(r);
            n_boxes++;
            if (!r.safe) n_unsafe++;
            cmd_count[r.command]++;
        endfunction

        function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void match_result(logic [39:0] beat);
            steer_t want, got;
            got.safe     = beat[0];
            got.command  = beat[3:1];
            got.distance = beat[11:4];
            got.offset_x = beat[22:12];
            got.offset_y = beat[33:23];
            if (due_cmds.size() == 0) begin
                errors++;
                $error("result beat with no box outstanding");
                return;
            end
            want = due_cmds.pop_front();
            if (got.safe !== want.safe) flag("safe", want.safe, got.safe);
            if (got.command !== want.command) flag("command", want.command, got.command);
            if (got.distance !== want.distance) flag("distance", want.distance, got.distance);
            if (got.offset_x !== want.offset_x)
                flag("offset_x", $signed(want.offset_x), $signed(got.offset_x));
            if (got.offset_y !== want.offset_y)
                flag("offset_y", $signed(want.offset_y), $signed(got.offset_y));
        endfunction

        function int pending();
            return due_cmds.size();
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives tracked boxes into the steering command core and checks every
// result beat against the steering checker. A directed set hits the field
// extremes, centre rounding, axis ties, every command and the clamp and
// zero-reference corners; random phases then feed slowly drifting box
// tracks mixed with jumps and noise under several register settings and
// idle/stall patterns, including one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbsc_pkg::*;
    import steer_checker_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_BOXES = 185;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        int aim_x, aim_y, gain, min_move, max_move, ref_w, ref_h, size_band;
    } regs_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [39:0]           i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [39:0]           o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    steer_checker board = new();
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic         rx_hold = 1'b0;
    event         hold_ev;
    int           n_settings = 0;
    int           trk_x, trk_y, trk_w, trk_h;

    tracked_box_steering_command_core u_dut (.*);

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                board.match_result(o_m_axis_tdata);
            if (!i_rst_n || rx_hold) begin
                i_m_axis_tready <= 1'b0;
            end else if (stall_pct != 0) begin
                i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : hold_off
        forever begin
            @(hold_ev);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    function automatic int clamp_px(int v);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    function automatic int jitter(int d);
        return int'($urandom_range(2 * d)) - d;
    endfunction

    function automatic box_t mk_box(int x, int y, int w, int h);
        box_t b;
        b.x = x[COORD_W-1:0];
        b.y = y[COORD_W-1:0];
        b.w = w[COORD_W-1:0];
        b.h = h[COORD_W-1:0];
        return b;
    endfunction

    function automatic void new_track();
        if ($urandom_range(99) < 70) begin
            trk_w = clamp_px(int'(board.ref_w) * int'($urandom_range(160, 40)) / 100);
            trk_h = clamp_px(int'(board.ref_h) * int'($urandom_range(160, 40)) / 100);
        end else begin
            trk_w = $urandom_range(1023);
            trk_h = $urandom_range(1023);
        end
        trk_x = $urandom_range(1023);
        trk_y = $urandom_range(1023);
    endfunction

    // mostly a slowly drifting track, some jumps and pure noise
    function automatic box_t next_box();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return mk_box($urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1023), $urandom_range(1023));
        if (pick < 6) begin
            new_track();
        end else begin
            trk_w = clamp_px(trk_w + jitter(trk_w >> 5));
            trk_h = clamp_px(trk_h + jitter(trk_h >> 5));
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            trk_x = clamp_px(int'(board.aim_x) - trk_w / 2 + jitter(8));
            trk_y = clamp_px(int'(board.aim_y) - trk_h / 2 + jitter(8));
        end else if (pick < 85) begin
            trk_x = clamp_px(trk_x + jitter(48));
            trk_y = clamp_px(trk_y + jitter(48));
        end else begin
            trk_x = $urandom_range(1023);
            trk_y = $urandom_range(1023);
        end
        return mk_box(trk_x, trk_y, trk_w, trk_h);
    endfunction

    task automatic send_box(input box_t b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.take_box(b);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        board.write_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic load_regs(input regs_t c, input bit with_ref);
        put_reg(CFG_AIM_X, c.aim_x);
        put_reg(CFG_AIM_Y, c.aim_y);
        put_reg(CFG_GAIN, c.gain);
        put_reg(CFG_MIN_MOVE, c.min_move);
        put_reg(CFG_MAX_MOVE, c.max_move);
        if (with_ref) begin
            put_reg(CFG_REF_W, c.ref_w);
            put_reg(CFG_REF_H, c.ref_h);
        end
        put_reg(CFG_SIZE_BAND, c.size_band);
        end_writes();
    endtask

    function automatic regs_t make_regs(int p);
        regs_t c;
        case (p)
            0: c = '{480, 360, 1229, 20, 60, 100, 80, 51};
            1: c = '{1023, 1023, 65535, 255, 255, 1023, 1023, 255};
            2: c = '{0, 0, 0, 0, 0, 1, 1, 0};
            default: begin
                c.aim_x     = $urandom_range(1023);
                c.aim_y     = $urandom_range(1023);
                c.gain      = ($urandom_range(99) < 20) ? $urandom_range(65535)
                                                        : $urandom_range(8191, 256);
                c.min_move  = $urandom_range(40);
                c.max_move  = ($urandom_range(99) < 25) ? $urandom_range(c.min_move)
                                                        : $urandom_range(255);
                c.ref_w     = ($urandom_range(99) < 70) ? $urandom_range(400, 16)
                                                        : $urandom_range(1023, 1);
                c.ref_h     = ($urandom_range(99) < 70) ? $urandom_range(400, 16)
                                                        : $urandom_range(1023, 1);
                c.size_band = ($urandom_range(99) < 70) ? $urandom_range(80, 10)
                                                        : $urandom_range(255);
            end
        endcase
        return c;
    endfunction

    task automatic run_directed();
        // reset register values
        send_box(mk_box(0, 0, 0, 0));
        send_box(mk_box(1023, 1023, 1023, 1023));
        send_box(mk_box(0, 0, 1, 1));
        send_box(mk_box(0, 0, 1023, 1023));
        send_box(mk_box(479, 359, 1, 3));
        send_box(mk_box(478, 360, 3, 0));
        send_box(mk_box(580, 460, 0, 0));
        send_box(mk_box(380, 260, 0, 0));
        send_box(mk_box(480, 200, 0, 0));
        send_box(mk_box(700, 360, 0, 0));
        send_box(mk_box(547, 360, 0, 0));
        send_box(mk_box(550, 360, 0, 0));
        send_box(mk_box(341, 682, 682, 341));
        drain();
        // clamp below the minimum
        put_reg(CFG_GAIN, 65535);
        put_reg(CFG_MIN_MOVE, 30);
        put_reg(CFG_MAX_MOVE, 10);
        end_writes();
        send_box(mk_box(1000, 360, 0, 0));
        send_box(mk_box(480, 360, 0, 0));
        drain();
        // zero references, zero step size
        put_reg(CFG_MIN_MOVE, 0);
        put_reg(CFG_REF_W, 0);
        put_reg(CFG_REF_H, 0);
        end_writes();
        send_box(mk_box(430, 310, 100, 100));
        drain();
        put_reg(CFG_REF_H, 200);
        end_writes();
        send_box(mk_box(480, 360, 0, 0));
        send_box(mk_box(430, 310, 100, 100));
        drain();
        put_reg(CFG_REF_W, 200);
        end_writes();
        send_box(mk_box(455, 335, 50, 50));
        drain();
    endtask

    initial begin : stimulus
        regs_t rc;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            rc = make_regs(p);
            // one phase keeps the history across the register update
            load_regs(rc, p != 5);
            new_track();
            if (p == 6) begin
                -> hold_ev;
                repeat (16) send_box(next_box());
            end
            repeat (PHASE_BOXES) send_box(next_box());
            drain();
        end

        repeat (40) @(posedge i_clk);
        $display("Checked %0d boxes over %0d register settings; %0d frames were unsafe.",
                 board.n_boxes, n_settings, board.n_unsafe);
        $display("Command mix none/right/left/up/down/back/forward: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 board.cmd_count[CMD_NONE], board.cmd_count[CMD_RIGHT],
                 board.cmd_count[CMD_LEFT], board.cmd_count[CMD_UP],
                 board.cmd_count[CMD_DOWN], board.cmd_count[CMD_BACK],
                 board.cmd_count[CMD_FORWARD]);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/tbsc_pkg.sv
rtl/core/tbsc_ctrl.sv
rtl/core/tbsc_dp.sv
rtl/core/tracked_box_steering_command_core.sv
dv/steer_checker_pkg.sv
dv/tb_top.sv
